// File: rtl/mwpm_pkg.sv
package mwpm_pkg;

	// Defaults for the top level parameters
	localparam int FRAC_BITS_DEF     = 14;
	localparam int CORDIC_STAGES_DEF = 16;

	// Stick components are carried with this many extra fraction bits
	localparam int WORK_SHIFT = 16;

	// 1/K of the CORDIC, Q30
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

	// Arctangent of 2^-i as a binary angle, 2^32 = one full turn
	localparam int ATAN_LEN = 24;
	localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// Drive request
	typedef struct packed {
		logic signed [15:0] stick_x;
		logic signed [15:0] stick_y;
		logic signed [15:0] turn_rate;
		logic        [14:0] speed_scale;
	} cmd_t;

	// Wheel powers, Q1.14
	typedef struct packed {
		logic signed [15:0] front_right_power;
		logic signed [15:0] front_left_power;
		logic signed [15:0] rear_right_power;
		logic signed [15:0] rear_left_power;
	} pwr_t;

endpackage

// File: rtl/mecanum_wheel_power_mixer.sv
// Channel | Direction | Handshake         | Payload
// cmd     | in        | cmd_valid / stall | mwpm_pkg::cmd_t (stick x/y, turn rate, speed)
// pwr     | out       | pwr_valid / stall | mwpm_pkg::pwr_t (four wheel powers)
//
// One request per cycle is taken while no result is stalled; each gives one result
// after an entry stage, one CORDIC iteration per stage, then two stages of magnitude
// scaling, then a multiply/round pair for each of gain, speed, and final speed.
// arst_n clears only the valid bits; data registers are not reset.
// A stalled result freezes the whole pipeline; cmd_stall is high only while the
// output register holds a result that is stalled.
module mecanum_wheel_power_mixer #(
	parameter int FRAC_BITS     = mwpm_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STAGES = mwpm_pkg::CORDIC_STAGES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  mwpm_pkg::cmd_t cmd,
	output logic           pwr_valid,
	input  logic           pwr_stall,
	output mwpm_pkg::pwr_t pwr
);

	localparam int N     = CORDIC_STAGES;
	localparam int WS    = mwpm_pkg::WORK_SHIFT;
	localparam int CW    = 16 + WS + 4;          // CORDIC datapath
	localparam int MAG_W = CW - 3;               // magnitude, unsigned
	localparam int RA_W  = 34;                   // gain * magnitude, rounded
	localparam int RS_W  = RA_W + 16;            // times speed
	localparam int MA_W  = RS_W - FRAC_BITS;     // move term
	localparam int SUM_W = ((MA_W > 32) ? MA_W : 32) + 2;
	localparam int FP_W  = SUM_W + 16;
	localparam int SH0   = FRAC_BITS + WS;
	localparam int SH1   = SH0 + 1;
	localparam int HI_INT = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);
	localparam int LO_INT = (FRAC_BITS >= 15) ? -32768 : -(1 << FRAC_BITS);

	localparam logic signed [32:0]      GAIN_ONE = 33'sh0_4000_0000;
	localparam logic signed [65:0]      RND30    = 66'sd536870912;
	localparam logic signed [RS_W-1:0]  RND_F    = RS_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [FP_W-1:0]  RND_SH0  = FP_W'(1) <<< (SH0 - 1);
	localparam logic signed [FP_W-1:0]  RND_SH1  = FP_W'(1) <<< (SH1 - 1);
	localparam logic signed [FP_W-1:0]  CLAMP_HI = FP_W'(HI_INT);
	localparam logic signed [FP_W-1:0]  CLAMP_LO = FP_W'(LO_INT);

	typedef struct packed {
		logic signed [15:0] turn;
		logic        [14:0] scale;
		logic               moving;
		logic               turning;
	} side_t;

	// Pipeline advances unless a finished result is stalled
	logic en;
	logic pwr_valid_q;
	mwpm_pkg::pwr_t pwr_q;
	mwpm_pkg::pwr_t pwr_w;

	assign en        = !(pwr_valid_q && pwr_stall);
	assign cmd_stall = !en;
	assign pwr_valid = pwr_valid_q;
	assign pwr       = pwr_q;

	// Entry: scale up, fold the left half plane onto the right
	logic signed [CW-1:0] in_x, in_y;
	side_t                in_sd;

	assign in_x = $signed({{(CW-16-WS){cmd.stick_x[15]}}, cmd.stick_x, {WS{1'b0}}});
	assign in_y = $signed({{(CW-16-WS){cmd.stick_y[15]}}, cmd.stick_y, {WS{1'b0}}});

	always_comb begin
		in_sd.turn    = cmd.turn_rate;
		in_sd.scale   = cmd.speed_scale;
		in_sd.moving  = (cmd.stick_x != '0) || (cmd.stick_y != '0);
		in_sd.turning = (cmd.turn_rate != '0);
	end

	logic signed [CW-1:0] cr_x_s [0:N];
	logic signed [CW-1:0] cr_y_s [0:N-1];
	logic        [31:0]   cr_z_s [0:N];
	side_t                cr_sd_s [0:N];
	logic                 cr_v_s [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_v_s[0] <= 1'b0;
		end else if (en) begin
			cr_v_s[0] <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr_x_s[0]  <= cmd.stick_x[15] ? -in_x : in_x;
			cr_y_s[0]  <= cmd.stick_x[15] ? -in_y : in_y;
			cr_z_s[0]  <= cmd.stick_x[15] ? 32'h8000_0000 : 32'h0;
			cr_sd_s[0] <= in_sd;
		end
	end

	// CORDIC vectoring, one iteration per stage
	for (genvar i = 0; i < N; i++) begin : g_cordic
		logic signed [CW-1:0] dx;
		logic                 up;

		assign dx = cr_y_s[i] >>> i;
		assign up = !cr_y_s[i][CW-1] && (cr_y_s[i] != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cr_v_s[i+1] <= 1'b0;
			end else if (en) begin
				cr_v_s[i+1] <= cr_v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cr_x_s[i+1]  <= up ? cr_x_s[i] + dx : cr_x_s[i] - dx;
				cr_z_s[i+1]  <= up ? cr_z_s[i] + mwpm_pkg::ATAN_TURNS[i]
				                   : cr_z_s[i] - mwpm_pkg::ATAN_TURNS[i];
				cr_sd_s[i+1] <= cr_sd_s[i];
			end
		end

		// y of the last iteration is not needed
		if (i < N - 1) begin : g_y
			logic signed [CW-1:0] dy;

			assign dy = cr_x_s[i] >>> i;

			always_ff @(posedge clk) begin
				if (en) begin
					cr_y_s[i+1] <= up ? cr_y_s[i] - dy : cr_y_s[i] + dy;
				end
			end
		end
	end

	// Angle and wheel gains (Q30) from quadrant and fraction
	logic        [31:0]       ang;
	logic signed [32:0]       two_f;
	logic signed [32:0]       ga_w, gb_w;
	logic        [MAG_W-1:0]  xu;

	assign ang   = 32'h8000_0000 - cr_z_s[N];
	assign two_f = $signed({2'b00, ang[29:0], 1'b0});
	assign xu    = cr_x_s[N][MAG_W-1:0];

	always_comb begin
		case (ang[31:30])
			2'd0: begin
				ga_w = GAIN_ONE - two_f;
				gb_w = GAIN_ONE;
			end
			2'd1: begin
				ga_w = -GAIN_ONE;
				gb_w = GAIN_ONE - two_f;
			end
			2'd2: begin
				ga_w = two_f - GAIN_ONE;
				gb_w = -GAIN_ONE;
			end
			default: begin
				ga_w = GAIN_ONE;
				gb_w = two_f - GAIN_ONE;
			end
		endcase
	end

	// Stage 2: magnitude partial products, gains
	logic [46:0]        plo_s2;
	logic [45:0]        phi_s2;
	logic signed [31:0] ga_s2, gb_s2;
	side_t              sd_s2;
	logic               v_s2;

	// Stage 3: rounded magnitude
	logic [63:0]        mag_sum;
	logic [MAG_W-1:0]   mag_s3;
	logic signed [31:0] ga_s3, gb_s3;
	side_t              sd_s3;
	logic               v_s3;

	// Stage 4: gain * magnitude
	logic signed [65:0] pa_s4, pb_s4;
	side_t              sd_s4;
	logic               v_s4;

	// Stage 5: rounded to magnitude units
	logic signed [65:0]     ra_w, rb_w;
	logic signed [RA_W-1:0] ra_s5, rb_s5;
	side_t                  sd_s5;
	logic                   v_s5;

	// Stage 6: times speed
	logic signed [RS_W-1:0] rsa_s6, rsb_s6;
	side_t                  sd_s6;
	logic                   v_s6;

	// Stage 7: move terms plus turn term
	logic signed [RS_W-1:0]  rma_w, rmb_w;
	logic signed [MA_W-1:0]  ma, mb;
	logic signed [33:0]      t_ext, tt;
	logic signed [SUM_W-1:0] ma_x, mb_x, tt_x;
	logic signed [SUM_W-1:0] sum_s7 [4];
	side_t                   sd_s7;
	logic                    v_s7;

	// Stage 8: times speed again
	logic signed [FP_W-1:0] fp_s8 [4];
	logic                   halve_s8;
	logic                   v_s8;

	assign mag_sum = {1'b0, phi_s2, 17'b0} + {17'b0, plo_s2} + 64'd536870912;
	assign ra_w    = pa_s4 + RND30;
	assign rb_w    = pb_s4 + RND30;
	assign rma_w   = rsa_s6 + RND_F;
	assign rmb_w   = rsb_s6 + RND_F;
	assign ma      = rma_w[RS_W-1:FRAC_BITS];
	assign mb      = rmb_w[RS_W-1:FRAC_BITS];
	assign t_ext   = 34'(sd_s6.turn);

	// Turn term: full weight while moving, 0.75 otherwise
	always_comb begin
		if (!sd_s6.turning) begin
			tt = '0;
		end else if (sd_s6.moving) begin
			tt = t_ext <<< WS;
		end else begin
			tt = (t_ext <<< (WS - 1)) + (t_ext <<< (WS - 2));
		end
		ma_x = sd_s6.moving ? SUM_W'(ma) : '0;
		mb_x = sd_s6.moving ? SUM_W'(mb) : '0;
		tt_x = SUM_W'(tt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			pwr_valid_q <= 1'b0;
		end else if (en) begin
			v_s2        <= cr_v_s[N];
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			pwr_valid_q <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s2 <= xu[16:0] * mwpm_pkg::INV_GAIN_Q30;
			phi_s2 <= xu[MAG_W-1:17] * mwpm_pkg::INV_GAIN_Q30;
			ga_s2  <= ga_w[31:0];
			gb_s2  <= gb_w[31:0];
			sd_s2  <= cr_sd_s[N];

			mag_s3 <= mag_sum[62:30];
			ga_s3  <= ga_s2;
			gb_s3  <= gb_s2;
			sd_s3  <= sd_s2;

			pa_s4  <= ga_s3 * $signed({1'b0, mag_s3});
			pb_s4  <= gb_s3 * $signed({1'b0, mag_s3});
			sd_s4  <= sd_s3;

			ra_s5  <= ra_w[RA_W+29:30];
			rb_s5  <= rb_w[RA_W+29:30];
			sd_s5  <= sd_s4;

			rsa_s6 <= ra_s5 * $signed({1'b0, sd_s5.scale});
			rsb_s6 <= rb_s5 * $signed({1'b0, sd_s5.scale});
			sd_s6  <= sd_s5;

			sum_s7[0] <= tt_x - ma_x;
			sum_s7[1] <= tt_x - mb_x;
			sum_s7[2] <= tt_x + mb_x;
			sum_s7[3] <= tt_x + ma_x;
			sd_s7     <= sd_s6;

			for (int k = 0; k < 4; k++) begin
				fp_s8[k] <= sum_s7[k] * $signed({1'b0, sd_s7.scale});
			end
			halve_s8 <= sd_s7.moving && sd_s7.turning;

			pwr_q <= pwr_w;
		end
	end

	// Final rounding (halved when moving and turning) and saturation
	function automatic logic signed [15:0] round_sat(input logic signed [FP_W-1:0] v,
	                                                 input logic halve);
		logic signed [FP_W-1:0] r0, r1, r;
		r0 = (v + RND_SH0) >>> SH0;
		r1 = (v + RND_SH1) >>> SH1;
		r  = halve ? r1 : r0;
		if (r > CLAMP_HI) begin
			r = CLAMP_HI;
		end else if (r < CLAMP_LO) begin
			r = CLAMP_LO;
		end
		return r[15:0];
	endfunction

	always_comb begin
		pwr_w.front_right_power = round_sat(fp_s8[0], halve_s8);
		pwr_w.front_left_power  = round_sat(fp_s8[1], halve_s8);
		pwr_w.rear_right_power  = round_sat(fp_s8[2], halve_s8);
		pwr_w.rear_left_power   = round_sat(fp_s8[3], halve_s8);
	end

endmodule

// File: rtl/mwpm_chk.sv
module mwpm_chk #(
	parameter int FRAC_BITS = mwpm_pkg::FRAC_BITS_DEF
) (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_stall,
	input logic           pwr_valid,
	input logic           pwr_stall,
	input mwpm_pkg::pwr_t pwr
);

	localparam logic signed [15:0] LIM = (FRAC_BITS >= 15) ? 16'sd32767
	                                     : 16'(1 << FRAC_BITS);
	// lower bound reaches the full 16 bit range once one is out of reach
	localparam logic signed [15:0] LIM_LO = (FRAC_BITS >= 15) ? 16'sh8000 : -LIM;

	// Every delivered power lies within plus or minus one
	a_pwr_range: assert property (@(posedge clk) disable iff (!arst_n)
		pwr_valid |->
			(pwr.front_right_power <= LIM) && (pwr.front_right_power >= LIM_LO) &&
			(pwr.front_left_power  <= LIM) && (pwr.front_left_power  >= LIM_LO) &&
			(pwr.rear_right_power  <= LIM) && (pwr.rear_right_power  >= LIM_LO) &&
			(pwr.rear_left_power   <= LIM) && (pwr.rear_left_power   >= LIM_LO))
		else $error("wheel power out of range");

	// A stalled result stays put
	a_pwr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pwr_valid && pwr_stall |=> pwr_valid && $stable(pwr))
		else $error("stalled result changed");

	// A stalled result at the output backs up the input
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pwr_valid && pwr_stall |-> cmd_stall)
		else $error("request taken while output is blocked");

	// With the output free the input is never stalled
	a_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		!pwr_valid || !pwr_stall |-> !cmd_stall)
		else $error("input stalled while output is free");

	// Reset empties the pipeline
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !pwr_valid)
		else $error("result present right after reset");

endmodule

bind mecanum_wheel_power_mixer mwpm_chk #(.FRAC_BITS(FRAC_BITS)) u_mwpm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_stall (cmd_stall),
	.pwr_valid (pwr_valid),
	.pwr_stall (pwr_stall),
	.pwr       (pwr)
);

// File: tb/mwpm_checker.sv
`default_nettype none

// Watches both channels of the wheel power mixer, predicts the four wheel powers
// for every accepted request and compares them with the results in order.
module mwpm_checker #(
	parameter int FRAC_BITS     = mwpm_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STAGES = mwpm_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	input  wire logic           cmd_stall,
	input  wire mwpm_pkg::cmd_t cmd,
	input  wire logic           pwr_valid,
	input  wire logic           pwr_stall,
	input  wire mwpm_pkg::pwr_t pwr,
	output int                  mismatches,
	output int                  pending,
	output int                  checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import mwpm_pkg::*;

	localparam int STAGES = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
	localparam longint GAIN_ONE = longint'(1) << 30;
	localparam longint PWR_MAX = ((longint'(1) << FRAC_BITS) > 32767) ?
		32767 : (longint'(1) << FRAC_BITS);
	localparam longint PWR_MIN = (-(longint'(1) << FRAC_BITS) < -32768) ?
		-32768 : -(longint'(1) << FRAC_BITS);

	pwr_t expected_powers[$];
	pwr_t want_pwr;

	initial begin
		mismatches = 0;
		pending    = 0;
		checked    = 0;
	end

	// floor(v / 2^n + 1/2)
	function automatic longint round_shift(longint v, int n);
		return (v + (longint'(1) << (n - 1))) >>> n;
	endfunction

	// Vectoring CORDIC: magnitude in stick units * 2^16, angle = pi - atan2(y, x)
	function automatic void stick_polar(input longint sx, input longint sy,
			output longint mag, output logic [31:0] ang);
		longint x;
		longint y;
		longint dx;
		longint dy;
		logic [31:0] z;
		int i;
		x = sx * (longint'(1) << WORK_SHIFT);
		y = sy * (longint'(1) << WORK_SHIFT);
		z = '0;
		// fold the left half plane onto the right
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		for (i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_TURNS[i];
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_TURNS[i];
			end
		end
		mag = round_shift(x * longint'(INV_GAIN_Q30), 30);
		ang = 32'h8000_0000 - z;
	endfunction

	// Trapezoidal wheel gains in Q30; B lags A by one quadrant
	function automatic longint wheel_gain(logic [31:0] ang, bit gain_b);
		longint f;
		f = longint'(ang[29:0]);
		if (!gain_b) begin
			case (ang[31:30])
				2'd0: return GAIN_ONE - 2 * f;
				2'd1: return -GAIN_ONE;
				2'd2: return -GAIN_ONE + 2 * f;
				default: return GAIN_ONE;
			endcase
		end
		case (ang[31:30])
			2'd0: return GAIN_ONE;
			2'd1: return GAIN_ONE - 2 * f;
			2'd2: return -GAIN_ONE;
			default: return -GAIN_ONE + 2 * f;
		endcase
	endfunction

	// Second speed scaling, optional halving, clamp to +-1.0
	function automatic logic signed [15:0] scale_clamp(longint sum, longint s, bit halve);
		longint v;
		v = round_shift(sum * s, FRAC_BITS + WORK_SHIFT + (halve ? 1 : 0));
		if (v > PWR_MAX)
			v = PWR_MAX;
		if (v < PWR_MIN)
			v = PWR_MIN;
		return v[15:0];
	endfunction

	function automatic pwr_t predict_powers(cmd_t c);
		longint x;
		longint y;
		longint t;
		longint s;
		longint mag;
		longint ma;
		longint mb;
		longint spin;
		longint p[4];
		logic [31:0] ang;
		bit moving;
		bit turning;
		pwr_t r;
		x = longint'(c.stick_x);
		y = longint'(c.stick_y);
		t = longint'(c.turn_rate);
		s = longint'(c.speed_scale);
		moving  = (x != 0) || (y != 0);
		turning = (t != 0);
		p = '{0, 0, 0, 0};
		// translation terms: FR, FL, RR, RL = -A, -B, +B, +A
		if (moving) begin
			stick_polar(x, y, mag, ang);
			ma = round_shift(round_shift(wheel_gain(ang, 1'b0) * mag, 30) * s, FRAC_BITS);
			mb = round_shift(round_shift(wheel_gain(ang, 1'b1) * mag, 30) * s, FRAC_BITS);
			p[0] = -ma;
			p[1] = -mb;
			p[2] = mb;
			p[3] = ma;
		end
		// rotation, at 3/4 when the stick is centered
		if (turning) begin
			spin = moving ? t * (longint'(1) << WORK_SHIFT) :
				t * 3 * (longint'(1) << (WORK_SHIFT - 2));
			for (int k = 0; k < 4; k++)
				p[k] = p[k] + spin;
		end
		r.front_right_power = scale_clamp(p[0], s, moving && turning);
		r.front_left_power  = scale_clamp(p[1], s, moving && turning);
		r.rear_right_power  = scale_clamp(p[2], s, moving && turning);
		r.rear_left_power   = scale_clamp(p[3], s, moving && turning);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= 50)
			$display("[%0t] result %0d: %s", $time, checked, msg);
	endtask

	task automatic compare_powers(pwr_t got, pwr_t want);
		if (got.front_right_power !== want.front_right_power)
			report_mismatch($sformatf("front_right_power %0d, expected %0d",
				got.front_right_power, want.front_right_power));
		if (got.front_left_power !== want.front_left_power)
			report_mismatch($sformatf("front_left_power %0d, expected %0d",
				got.front_left_power, want.front_left_power));
		if (got.rear_right_power !== want.rear_right_power)
			report_mismatch($sformatf("rear_right_power %0d, expected %0d",
				got.rear_right_power, want.rear_right_power));
		if (got.rear_left_power !== want.rear_left_power)
			report_mismatch($sformatf("rear_left_power %0d, expected %0d",
				got.rear_left_power, want.rear_left_power));
	endtask

	// Requests in, results out, both sampled at the edge they are accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				expected_powers.push_back(predict_powers(cmd));
			if (pwr_valid && !pwr_stall) begin
				if (expected_powers.size() == 0) begin
					report_mismatch("wheel powers arrived with no request outstanding");
				end else begin
					want_pwr = expected_powers.pop_front();
					compare_powers(pwr, want_pwr);
				end
				checked++;
			end
			pending <= expected_powers.size();
		end
	end

endmodule

`default_nettype wire

// File: tb/tb_mecanum_wheel_power_mixer.sv
`default_nettype none

module tb_mecanum_wheel_power_mixer;
	timeunit 1ns;
	timeprecision 1ps;

	import mwpm_pkg::*;

	localparam int RANDOM_REQS = 1650;
	localparam int FLUSH_CYCLES = CORDIC_STAGES_DEF + 20;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic pwr_valid;
	logic pwr_stall;
	pwr_t pwr;

	int mismatches;
	int pending;
	int checked;

	int n_directed;
	int n_random;
	int n_move_turn;
	int n_move_only;
	int n_turn_only;
	int n_idle;

	cmd_t directed_cmds[$];

	mecanum_wheel_power_mixer #(
		.FRAC_BITS    (FRAC_BITS_DEF),
		.CORDIC_STAGES(CORDIC_STAGES_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.pwr_valid(pwr_valid),
		.pwr_stall(pwr_stall),
		.pwr      (pwr)
	);

	mwpm_checker #(
		.FRAC_BITS    (FRAC_BITS_DEF),
		.CORDIC_STAGES(CORDIC_STAGES_DEF)
	) chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.pwr_valid (pwr_valid),
		.pwr_stall (pwr_stall),
		.pwr       (pwr),
		.mismatches(mismatches),
		.pending   (pending),
		.checked   (checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop if the run hangs
	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	// Mostly short gaps, a few long ones
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic cmd_t make_cmd(int x, int y, int t, int s);
		cmd_t c;
		c.stick_x     = 16'(x);
		c.stick_y     = 16'(y);
		c.turn_rate   = 16'(t);
		c.speed_scale = 15'(s);
		return c;
	endfunction

	function automatic int rand_q14();
		return int'($urandom_range(0, 32768)) - 16384;
	endfunction

	function automatic int rand_axis();
		case ($urandom_range(0, 2))
			0: return -16384;
			1: return 0;
			default: return 16384;
		endcase
	endfunction

	function automatic int rand_scale();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 16384);
		if (r < 88)
			return int'(15'($urandom));
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 1;
			2: return 16384;
			default: return 32767;
		endcase
	endfunction

	function automatic cmd_t random_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return make_cmd(rand_q14(), rand_q14(), rand_q14(), rand_scale());
		if (r < 70)
			return make_cmd(0, 0, rand_q14(), rand_scale());
		if (r < 78)
			return make_cmd(rand_q14(), rand_q14(), 0, rand_scale());
		if (r < 84)
			return make_cmd(rand_axis(), rand_axis(), rand_axis(), rand_scale());
		if (r < 86)
			return make_cmd(0, 0, 0, rand_scale());
		// full 16 bit patterns, beyond +-1.0
		return make_cmd(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
			int'($signed(16'($urandom))), rand_scale());
	endfunction

	// Idle for gap cycles, then present one request and hold it until taken
	task automatic send_request(cmd_t c, int gap);
		bit moving;
		moving = (c.stick_x != 0) || (c.stick_y != 0);
		if (moving && c.turn_rate != 0)
			n_move_turn++;
		else if (moving)
			n_move_only++;
		else if (c.turn_rate != 0)
			n_turn_only++;
		else
			n_idle++;
		repeat (gap) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (cmd_stall);
	endtask

	// Stop sending until every outstanding result is back
	task automatic drain_results();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Result side back pressure
	initial begin
		int run;
		int hold;
		pwr_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			run = ($urandom_range(0, 11) == 0) ? $urandom_range(100, 400) :
				$urandom_range(1, 6);
			pwr_stall <= 1'b0;
			repeat (run) @(posedge clk);
			hold = $urandom_range(0, 99);
			hold = (hold < 80) ? $urandom_range(1, 3) :
				(hold < 97) ? $urandom_range(4, 12) : $urandom_range(20, 60);
			pwr_stall <= 1'b1;
			repeat (hold) @(posedge clk);
		end
	end

	// Stimulus
	initial begin
		int gap;
		arst_n      = 1'b0;
		cmd_valid   = 1'b0;
		cmd         = '0;
		n_directed  = 0;
		n_random    = 0;
		n_move_turn = 0;
		n_move_only = 0;
		n_turn_only = 0;
		n_idle      = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero input, axes, diagonals, turn only, combined, extremes
		directed_cmds.push_back(make_cmd(0, 0, 0, 16384));
		directed_cmds.push_back(make_cmd(16384, 0, 0, 16384));
		directed_cmds.push_back(make_cmd(-16384, 0, 0, 16384));
		directed_cmds.push_back(make_cmd(0, 16384, 0, 16384));
		directed_cmds.push_back(make_cmd(0, -16384, 0, 16384));
		directed_cmds.push_back(make_cmd(16384, 16384, 0, 16384));
		directed_cmds.push_back(make_cmd(-16384, -16384, 0, 16384));
		directed_cmds.push_back(make_cmd(-16384, 16384, 0, 12000));
		directed_cmds.push_back(make_cmd(0, 0, 16384, 16384));
		directed_cmds.push_back(make_cmd(0, 0, -16384, 16384));
		directed_cmds.push_back(make_cmd(16384, 0, 16384, 16384));
		directed_cmds.push_back(make_cmd(16384, 16384, -16384, 16384));
		directed_cmds.push_back(make_cmd(-32768, -32768, -32768, 32767));
		directed_cmds.push_back(make_cmd(32767, 32767, 32767, 32767));
		directed_cmds.push_back(make_cmd(-32768, 0, 0, 32767));
		directed_cmds.push_back(make_cmd(0, -32768, 0, 16384));
		directed_cmds.push_back(make_cmd(0, 0, -32768, 32767));
		directed_cmds.push_back(make_cmd(12000, -9000, 0, 0));
		directed_cmds.push_back(make_cmd(1, 0, 0, 16384));
		directed_cmds.push_back(make_cmd(0, -1, 0, 16384));
		directed_cmds.push_back(make_cmd(-1, 1, 1, 1));
		directed_cmds.push_back(make_cmd(5000, -12000, -3000, 9000));
		directed_cmds.push_back(make_cmd(0, 0, 0, 0));
		foreach (directed_cmds[i]) begin
			send_request(directed_cmds[i], rand_gap());
			n_directed++;
		end
		drain_results();

		// random: back-to-back stretches, gaps elsewhere, a full drain midway
		for (int i = 0; i < RANDOM_REQS; i++) begin
			gap = ((i % 300) < 60) ? 0 : rand_gap();
			send_request(random_cmd(), gap);
			n_random++;
			if (i == RANDOM_REQS / 2)
				drain_results();
		end
		drain_results();
		// catch any result nobody asked for
		repeat (FLUSH_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d directed, %0d random): %0d move+turn, %0d move only,",
			n_directed + n_random, n_directed, n_random, n_move_turn, n_move_only);
		$display("%0d turn only, %0d centered and still; %0d wheel power results compared",
			n_turn_only, n_idle, checked);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
